// ===== design/adcscan_pkg.sv =====
// Shared types and constants for the converter scan sequencer.
package adcscan_pkg;

   localparam int DEV_W     = 3;
   localparam int CH_W      = 3;
   localparam int START_W   = 2;
   localparam int MASK_W    = 4;
   localparam int TIMEOUT_W = 16;
   localparam int TIME_W    = 32;
   localparam int SAMPLE_W  = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESENT_MASK = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_MS   = 1'b1;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;

   localparam logic KIND_POLL = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic               new_reading;
      logic               start_issued;
      logic [START_W-1:0] start_device;
      logic [START_W-1:0] start_channel;
      logic               timed_out;
   } poll_res_type;

   typedef struct packed {
      logic                       store;
      logic                       invalidate;
      logic [DEV_W-1:0]           device;
      logic [CH_W-1:0]            channel;
      logic signed [SAMPLE_W-1:0] value;
      logic [TIME_W-1:0]          stamp;
   } store_cmd_type;

endpackage

// ===== design/adcscan_ctrl.sv =====
// Scan position, pending conversion tracking and poll decisions.
module adcscan_ctrl
   import adcscan_pkg::*;
#(
   parameter int NUM_DEVICES  = 4,
   parameter int NUM_CHANNELS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  logic                       kind,
   input  logic [TIME_W-1:0]          now_ms,
   input  logic                       conv_done,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic [MASK_W-1:0]          present_mask,
   input  logic [TIMEOUT_W-1:0]       timeout_ms,
   output poll_res_type               poll_res,
   output store_cmd_type              store_cmd,
   output logic                       store_en
);

   localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

   logic [DEV_W-1:0]  cur_device_ff, cur_device_in;
   logic [CH_W-1:0]   cur_channel_ff, cur_channel_in;
   logic              busy_ff, busy_in;
   logic [TIME_W-1:0] start_time_ff, start_time_in;

   logic [MASK_W-1:0] eff_mask;
   logic              any_present;
   logic              cur_present;
   logic [DEV_W-1:0]  lowest_dev;
   logic [DEV_W-1:0]  next_dev;
   logic              next_found;
   logic [DEV_W-1:0]  adv_device;
   logic [CH_W-1:0]   adv_channel;
   logic [TIME_W-1:0] elapsed;
   logic              expired;
   logic              is_poll;
   logic [DEV_W-1:0]  idle_device;
   logic [CH_W-1:0]   idle_channel;

   always_comb begin
      for (int d = 0; d < MASK_W; d++) begin
         eff_mask[d] = present_mask[d] && (d < NUM_DEVICES);
      end
   end

   assign any_present = |eff_mask;
   assign cur_present = (cur_device_ff < DEV_W'(MASK_W)) && eff_mask[cur_device_ff[1:0]];

   always_comb begin
      lowest_dev = '0;
      next_dev   = '0;
      next_found = 1'b0;
      for (int d = MASK_W - 1; d >= 0; d--) begin
         if (eff_mask[d]) begin
            lowest_dev = DEV_W'(d);
         end
         if (eff_mask[d] && (DEV_W'(d) > cur_device_ff)) begin
            next_dev   = DEV_W'(d);
            next_found = 1'b1;
         end
      end
   end

   always_comb begin
      if (cur_channel_ff >= LAST_CH) begin
         adv_channel = '0;
         adv_device  = next_found ? next_dev : lowest_dev;
      end else begin
         adv_channel = cur_channel_ff + CH_W'(1);
         adv_device  = cur_device_ff;
      end
   end

   assign elapsed = now_ms - start_time_ff;
   assign expired = elapsed > {{(TIME_W - TIMEOUT_W){1'b0}}, timeout_ms};
   assign is_poll = (kind == KIND_POLL);
   assign idle_device  = cur_present ? cur_device_ff : lowest_dev;
   assign idle_channel = cur_present ? cur_channel_ff : '0;

   always_comb begin
      cur_device_in     = cur_device_ff;
      cur_channel_in    = cur_channel_ff;
      busy_in           = busy_ff;
      start_time_in     = start_time_ff;
      poll_res          = '0;
      store_cmd         = '0;
      store_cmd.device  = cur_device_ff;
      store_cmd.channel = cur_channel_ff;
      store_cmd.value   = sample;
      store_cmd.stamp   = now_ms;
      if (is_poll) begin
         priority if (!any_present) begin
            busy_in = 1'b0;
         end else if (!busy_ff) begin
            cur_device_in          = idle_device;
            cur_channel_in         = idle_channel;
            busy_in                = 1'b1;
            start_time_in          = now_ms;
            poll_res.start_issued  = 1'b1;
            poll_res.start_device  = idle_device[START_W-1:0];
            poll_res.start_channel = idle_channel[START_W-1:0];
         end else if (!cur_present || (cur_channel_ff > LAST_CH)) begin
            busy_in = 1'b0;
         end else if (conv_done || expired) begin
            store_cmd.store        = conv_done;
            store_cmd.invalidate   = !conv_done;
            poll_res.new_reading   = conv_done;
            poll_res.timed_out     = !conv_done;
            cur_device_in          = adv_device;
            cur_channel_in         = adv_channel;
            busy_in                = 1'b1;
            start_time_in          = now_ms;
            poll_res.start_issued  = 1'b1;
            poll_res.start_device  = adv_device[START_W-1:0];
            poll_res.start_channel = adv_channel[START_W-1:0];
         end else begin
            busy_in = busy_ff;
         end
      end
   end

   assign store_en = fire && is_poll;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_device_ff  <= '0;
         cur_channel_ff <= '0;
         busy_ff        <= 1'b0;
         start_time_ff  <= '0;
      end else if (store_en) begin
         cur_device_ff  <= cur_device_in;
         cur_channel_ff <= cur_channel_in;
         busy_ff        <= busy_in;
         start_time_ff  <= start_time_in;
      end
   end

   a_start_sets_busy : assert property (@(posedge clock) disable iff (reset)
      store_en && poll_res.start_issued |=> busy_ff && (start_time_ff == $past(now_ms)))
      else $error("start issued without a pending conversion");

   a_timeout_clears_entry : assert property (@(posedge clock) disable iff (reset)
      store_en && poll_res.timed_out |-> store_cmd.invalidate && !store_cmd.store)
      else $error("timeout without entry invalidation");

   a_channel_in_range : assert property (@(posedge clock) disable iff (reset)
      cur_channel_ff <= LAST_CH)
      else $error("scan channel out of range");

endmodule

// ===== design/adcscan_store.sv =====
// Storage of scanned readings with registered read port.
module adcscan_store
   import adcscan_pkg::*;
#(
   parameter int NUM_DEVICES  = 4,
   parameter int NUM_CHANNELS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       store_en,
   input  store_cmd_type              store_cmd,
   input  logic                       rd_en,
   input  logic                       rd_req,
   input  logic [DEV_W-1:0]           rd_device,
   input  logic [CH_W-1:0]            rd_channel,
   output logic signed [SAMPLE_W-1:0] rd_value,
   output logic [TIME_W-1:0]          rd_stamp,
   output logic                       rd_valid
);

   localparam int NUM_ENTRIES = NUM_DEVICES * NUM_CHANNELS;
   localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int PROD_W      = DEV_W + CH_W + 1;

   logic signed [SAMPLE_W-1:0] value_mem [NUM_ENTRIES];
   logic [TIME_W-1:0]          stamp_mem [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0]     written_ff;
   logic [NUM_ENTRIES-1:0]     valid_ff;

   logic signed [SAMPLE_W-1:0] value_ff;
   logic [TIME_W-1:0]          stamp_ff;
   logic                       hit_ff, hit_in;
   logic                       valid_out_ff, valid_out_in;

   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;
   logic             rd_in_range;

   assign wr_idx = IDX_W'(PROD_W'(store_cmd.device) * PROD_W'(NUM_CHANNELS)
                          + PROD_W'(store_cmd.channel));

   assign rd_in_range = (PROD_W'(rd_device) < PROD_W'(NUM_DEVICES))
                     && (PROD_W'(rd_channel) < PROD_W'(NUM_CHANNELS));

   assign rd_idx = rd_in_range
                 ? IDX_W'(PROD_W'(rd_device) * PROD_W'(NUM_CHANNELS) + PROD_W'(rd_channel))
                 : '0;

   assign hit_in       = rd_req && rd_in_range && written_ff[rd_idx];
   assign valid_out_in = hit_in && valid_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (store_en && store_cmd.store) begin
         value_mem[wr_idx] <= store_cmd.value;
         stamp_mem[wr_idx] <= store_cmd.stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         value_ff     <= value_mem[rd_idx];
         stamp_ff     <= stamp_mem[rd_idx];
         hit_ff       <= hit_in;
         valid_out_ff <= valid_out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         valid_ff   <= '0;
      end else if (store_en) begin
         if (store_cmd.store) begin
            written_ff[wr_idx] <= 1'b1;
            valid_ff[wr_idx]   <= 1'b1;
         end else if (store_cmd.invalidate) begin
            valid_ff[wr_idx] <= 1'b0;
         end
      end
   end

   assign rd_value = hit_ff ? value_ff : '0;
   assign rd_stamp = hit_ff ? stamp_ff : '0;
   assign rd_valid = valid_out_ff;

endmodule

// ===== design/adc_round_robin_scan_sequencer.sv =====
// Top level of the round robin converter scan sequencer.
// A request goes into the input register and its result into the result register.
// Throughput: one request per cycle; the input register, the decision logic and the
// result register form a two stage pipeline that stalls only on rsp_ready.
// Reset clears the scan position, the pending flag and the written and valid flags of
// all stored readings, and sets present_mask to 0 and timeout_ms to 100.
module adc_round_robin_scan_sequencer
   import adcscan_pkg::*;
#(
   parameter int NUM_DEVICES  = 4,
   parameter int NUM_CHANNELS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_kind,
   input  logic [TIME_W-1:0]          req_now_ms,
   input  logic                       req_conv_done,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic [DEV_W-1:0]           req_read_device,
   input  logic [CH_W-1:0]            req_read_channel,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_new_reading,
   output logic                       rsp_start_issued,
   output logic [START_W-1:0]         rsp_start_device,
   output logic [START_W-1:0]         rsp_start_channel,
   output logic                       rsp_timed_out,
   output logic signed [SAMPLE_W-1:0] rsp_read_value,
   output logic [TIME_W-1:0]          rsp_read_time,
   output logic                       rsp_read_valid
);

   logic [MASK_W-1:0]    present_mask_ff;
   logic [TIMEOUT_W-1:0] timeout_ms_ff;

   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_kind_ff;
   logic [TIME_W-1:0]          s1_now_ff;
   logic                       s1_done_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic [DEV_W-1:0]           s1_rd_device_ff;
   logic [CH_W-1:0]            s1_rd_channel_ff;

   logic         rsp_valid_ff, rsp_valid_in;
   poll_res_type res_ff;
   poll_res_type poll_res;

   store_cmd_type store_cmd;
   logic          store_en;
   logic          advance;
   logic          fire;
   logic          req_take;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_mask_ff <= '0;
         timeout_ms_ff   <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PRESENT_MASK: present_mask_ff <= csr_wr_data[MASK_W-1:0];
            CSR_TIMEOUT_MS:   timeout_ms_ff   <= csr_wr_data[TIMEOUT_W-1:0];
            default:          timeout_ms_ff   <= timeout_ms_ff;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff       <= req_kind;
         s1_now_ff        <= req_now_ms;
         s1_done_ff       <= req_conv_done;
         s1_sample_ff     <= req_sample;
         s1_rd_device_ff  <= req_read_device;
         s1_rd_channel_ff <= req_read_channel;
      end
      if (fire) begin
         res_ff <= poll_res;
      end
   end

   adcscan_ctrl #(
      .NUM_DEVICES  (NUM_DEVICES),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .kind         (s1_kind_ff),
      .now_ms       (s1_now_ff),
      .conv_done    (s1_done_ff),
      .sample       (s1_sample_ff),
      .present_mask (present_mask_ff),
      .timeout_ms   (timeout_ms_ff),
      .poll_res     (poll_res),
      .store_cmd    (store_cmd),
      .store_en     (store_en)
   );

   adcscan_store #(
      .NUM_DEVICES  (NUM_DEVICES),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .store_en   (store_en),
      .store_cmd  (store_cmd),
      .rd_en      (fire),
      .rd_req     (s1_kind_ff == KIND_READ),
      .rd_device  (s1_rd_device_ff),
      .rd_channel (s1_rd_channel_ff),
      .rd_value   (rsp_read_value),
      .rd_stamp   (rsp_read_time),
      .rd_valid   (rsp_read_valid)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_reading   = res_ff.new_reading;
   assign rsp_start_issued  = res_ff.start_issued;
   assign rsp_start_device  = res_ff.start_device;
   assign rsp_start_channel = res_ff.start_channel;
   assign rsp_timed_out     = res_ff.timed_out;

endmodule

// ===== tb/sv/scan_result_checker.sv =====
// Checker that predicts every scan sequencer result and compares it with the block's output.
module scan_result_checker
   import adcscan_pkg::*;
#(
   parameter int NUM_DEVICES  = 4,
   parameter int NUM_CHANNELS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wr_data,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       req_kind,
   input  logic [TIME_W-1:0]          req_now_ms,
   input  logic                       req_conv_done,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic [DEV_W-1:0]           req_read_device,
   input  logic [CH_W-1:0]            req_read_channel,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_new_reading,
   input  logic                       rsp_start_issued,
   input  logic [START_W-1:0]         rsp_start_device,
   input  logic [START_W-1:0]         rsp_start_channel,
   input  logic                       rsp_timed_out,
   input  logic signed [SAMPLE_W-1:0] rsp_read_value,
   input  logic [TIME_W-1:0]          rsp_read_time,
   input  logic                       rsp_read_valid,
   output int                         mismatch_count,
   output int                         results_due
);

   localparam int NUM_ENTRIES = NUM_DEVICES * NUM_CHANNELS;

   typedef struct packed {
      poll_res_type               poll;
      logic signed [SAMPLE_W-1:0] read_value;
      logic [TIME_W-1:0]          read_time;
      logic                       read_valid;
   } scan_result_type;

   logic [MASK_W-1:0]          present_q;
   logic [TIMEOUT_W-1:0]       timeout_q;
   int                         scan_device;
   int                         scan_channel;
   logic                       conv_pending;
   logic [TIME_W-1:0]          conv_started;
   logic signed [SAMPLE_W-1:0] stored_value [NUM_ENTRIES];
   logic [TIME_W-1:0]          stored_time [NUM_ENTRIES];
   logic                       stored_valid [NUM_ENTRIES];
   scan_result_type            due_results [$];

   function automatic logic device_present(int dev);
      if (dev >= NUM_DEVICES || dev >= MASK_W) return 1'b0;
      return present_q[dev];
   endfunction

   function automatic int first_present_from(int dev);
      while (dev < NUM_DEVICES && !device_present(dev)) dev++;
      return dev;
   endfunction

   function automatic void advance_scan();
      int d;
      if (scan_channel + 1 < NUM_CHANNELS) begin
         scan_channel++;
      end else begin
         scan_channel = 0;
         d = first_present_from(scan_device + 1);
         if (d >= NUM_DEVICES) d = first_present_from(0);
         scan_device = (d >= NUM_DEVICES) ? 0 : d;
      end
   endfunction

   function automatic poll_res_type start_conversion(logic [TIME_W-1:0] now,
                                                     poll_res_type poll);
      conv_pending = device_present(scan_device);
      if (conv_pending) begin
         conv_started       = now;
         poll.start_issued  = 1'b1;
         poll.start_device  = START_W'(scan_device);
         poll.start_channel = START_W'(scan_channel);
      end
      return poll;
   endfunction

   function automatic scan_result_type predict_scan_step(logic kind, logic [TIME_W-1:0] now,
         logic done, logic signed [SAMPLE_W-1:0] sample, logic [DEV_W-1:0] rd,
         logic [CH_W-1:0] rc);
      scan_result_type res;
      int k;
      res = '0;
      if (kind == KIND_READ) begin
         if (rd < NUM_DEVICES && rc < NUM_CHANNELS) begin
            k = rd * NUM_CHANNELS + rc;
            res.read_value = stored_value[k];
            res.read_time  = stored_time[k];
            res.read_valid = stored_valid[k];
         end
         return res;
      end
      if (first_present_from(0) >= NUM_DEVICES) begin
         conv_pending = 1'b0;
      end else if (!conv_pending) begin
         if (!device_present(scan_device)) begin
            scan_device  = first_present_from(0);
            scan_channel = 0;
         end
         res.poll = start_conversion(now, res.poll);
      end else if (!device_present(scan_device)) begin
         conv_pending = 1'b0;
      end else if (done || (now - conv_started) > TIME_W'(timeout_q)) begin
         k = scan_device * NUM_CHANNELS + scan_channel;
         if (done) begin
            stored_value[k]      = sample;
            stored_time[k]       = now;
            stored_valid[k]      = 1'b1;
            res.poll.new_reading = 1'b1;
         end else begin
            stored_valid[k]    = 1'b0;
            res.poll.timed_out = 1'b1;
         end
         advance_scan();
         res.poll = start_conversion(now, res.poll);
      end
      return res;
   endfunction

   function automatic int field_mismatch(string name, logic [TIME_W-1:0] want,
                                         logic [TIME_W-1:0] got);
      if (want === got) return 0;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      scan_result_type want;
      scan_result_type got;
      int errors;
      errors = 0;
      if (reset) begin
         present_q    = '0;
         timeout_q    = TIMEOUT_RESET;
         scan_device  = 0;
         scan_channel = 0;
         conv_pending = 1'b0;
         conv_started = '0;
         foreach (stored_value[k]) begin
            stored_value[k] = '0;
            stored_time[k]  = '0;
            stored_valid[k] = 1'b0;
         end
         due_results.delete();
         mismatch_count <= 0;
         results_due    <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PRESENT_MASK: present_q = csr_wr_data[MASK_W-1:0];
               CSR_TIMEOUT_MS:   timeout_q = csr_wr_data[TIMEOUT_W-1:0];
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got.poll.new_reading   = rsp_new_reading;
            got.poll.start_issued  = rsp_start_issued;
            got.poll.start_device  = rsp_start_device;
            got.poll.start_channel = rsp_start_channel;
            got.poll.timed_out     = rsp_timed_out;
            got.read_value         = rsp_read_value;
            got.read_time          = rsp_read_time;
            got.read_valid         = rsp_read_valid;
            if (due_results.size() == 0) begin
               $display("%0t: result with no request waiting, expected none actual %h",
                        $time, got);
               errors++;
            end else begin
               want = due_results.pop_front();
               errors += field_mismatch("new_reading", want.poll.new_reading,
                                        got.poll.new_reading);
               errors += field_mismatch("start_issued", want.poll.start_issued,
                                        got.poll.start_issued);
               errors += field_mismatch("start_device", want.poll.start_device,
                                        got.poll.start_device);
               errors += field_mismatch("start_channel", want.poll.start_channel,
                                        got.poll.start_channel);
               errors += field_mismatch("timed_out", want.poll.timed_out, got.poll.timed_out);
               errors += field_mismatch("read_value", want.read_value, got.read_value);
               errors += field_mismatch("read_time", want.read_time, got.read_time);
               errors += field_mismatch("read_valid", want.read_valid, got.read_valid);
            end
         end
         if (req_valid && req_ready) begin
            due_results.push_back(predict_scan_step(req_kind, req_now_ms, req_conv_done,
                                                    req_sample, req_read_device,
                                                    req_read_channel));
         end
         results_due    <= due_results.size();
         mismatch_count <= mismatch_count + errors;
      end
   end

endmodule

// ===== tb/sv/tb_adc_round_robin_scan_sequencer.sv =====
// Testbench top for the scan sequencer: stimulus, back-pressure, watchdog and verdict.
module tb_adc_round_robin_scan_sequencer
   import adcscan_pkg::*;
();

   localparam int NUM_DEVICES    = 4;
   localparam int NUM_CHANNELS   = 4;
   localparam int PHASES         = 8;
   localparam int PHASE_REQUESTS = 66;
   localparam int LONG_HOLD      = 300;
   localparam int IDLE_LIMIT     = 2000;

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_wr_data;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_kind;
   logic [TIME_W-1:0]          req_now_ms;
   logic                       req_conv_done;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic [DEV_W-1:0]           req_read_device;
   logic [CH_W-1:0]            req_read_channel;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic                       rsp_new_reading;
   logic                       rsp_start_issued;
   logic [START_W-1:0]         rsp_start_device;
   logic [START_W-1:0]         rsp_start_channel;
   logic                       rsp_timed_out;
   logic signed [SAMPLE_W-1:0] rsp_read_value;
   logic [TIME_W-1:0]          rsp_read_time;
   logic                       rsp_read_valid;
   int                         mismatch_count;
   int                         results_due;
   logic                       sender_steady;
   logic                       hold_request;

   adc_round_robin_scan_sequencer #(
      .NUM_DEVICES  (NUM_DEVICES),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_now_ms        (req_now_ms),
      .req_conv_done     (req_conv_done),
      .req_sample        (req_sample),
      .req_read_device   (req_read_device),
      .req_read_channel  (req_read_channel),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_new_reading   (rsp_new_reading),
      .rsp_start_issued  (rsp_start_issued),
      .rsp_start_device  (rsp_start_device),
      .rsp_start_channel (rsp_start_channel),
      .rsp_timed_out     (rsp_timed_out),
      .rsp_read_value    (rsp_read_value),
      .rsp_read_time     (rsp_read_time),
      .rsp_read_valid    (rsp_read_valid)
   );

   scan_result_checker #(
      .NUM_DEVICES  (NUM_DEVICES),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) scan_check (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_now_ms        (req_now_ms),
      .req_conv_done     (req_conv_done),
      .req_sample        (req_sample),
      .req_read_device   (req_read_device),
      .req_read_channel  (req_read_channel),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_new_reading   (rsp_new_reading),
      .rsp_start_issued  (rsp_start_issued),
      .rsp_start_device  (rsp_start_device),
      .rsp_start_channel (rsp_start_channel),
      .rsp_timed_out     (rsp_timed_out),
      .rsp_read_value    (rsp_read_value),
      .rsp_read_time     (rsp_read_time),
      .rsp_read_valid    (rsp_read_valid),
      .mismatch_count    (mismatch_count),
      .results_due       (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_request(input logic kind, input logic [TIME_W-1:0] now,
                               input logic done, input logic [SAMPLE_W-1:0] sample,
                               input logic [DEV_W-1:0] rd, input logic [CH_W-1:0] rc);
      int gap;
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_now_ms       <= now;
      req_conv_done    <= done;
      req_sample       <= sample;
      req_read_device  <= rd;
      req_read_channel <= rc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_poll(input logic [TIME_W-1:0] now, input logic done,
                            input logic [SAMPLE_W-1:0] sample);
      send_request(KIND_POLL, now, done, sample, DEV_W'($urandom), CH_W'($urandom));
   endtask

   task automatic send_read(input logic [DEV_W-1:0] rd, input logic [CH_W-1:0] rc);
      send_request(KIND_READ, $urandom, 1'($urandom), SAMPLE_W'($urandom), rd, rc);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   task automatic configure(input logic [MASK_W-1:0] mask,
                            input logic [TIMEOUT_W-1:0] timeout);
      drain_results();
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_PRESENT_MASK;
      csr_wr_data <= CSR_DATA_W'(mask);
      @(posedge clock);
      csr_index   <= CSR_TIMEOUT_MS;
      csr_wr_data <= CSR_DATA_W'(timeout);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int burst;
      int gap;
      logic held;
      held = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            burst = $urandom_range(1, 24);
            repeat (burst) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic [TIME_W-1:0]    now_ms;
      logic [MASK_W-1:0]    mask;
      logic [TIMEOUT_W-1:0] timeout;
      logic [DEV_W-1:0]     rd;
      logic [CH_W-1:0]      rc;
      sender_steady = 1'b0;
      hold_request     <= 1'b0;
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_PRESENT_MASK;
      csr_wr_data      <= '0;
      req_valid        <= 1'b0;
      req_kind         <= KIND_POLL;
      req_now_ms       <= '0;
      req_conv_done    <= 1'b0;
      req_sample       <= '0;
      req_read_device  <= '0;
      req_read_channel <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // With no converter present a poll does nothing; reads see the cleared table.
      send_poll(32'd0, 1'b0, 16'h0000);
      send_read(3'd0, 3'd0);
      send_read(3'd4, 3'd0);
      send_read(3'd0, 3'd7);

      // Converters 1 and 3 only, zero timeout: the scan skips converter 0.
      configure(4'b1010, 16'd0);
      send_poll(32'd10, 1'b0, 16'h0000);
      send_poll(32'd10, 1'b0, 16'h0000);
      send_poll(32'd11, 1'b0, 16'h0000);
      send_poll(32'd11, 1'b1, 16'h7FFF);
      send_poll(32'hFFFF_FFFF, 1'b1, 16'h8000);
      send_poll(32'd0, 1'b1, 16'h0001);
      send_read(3'd1, 3'd1);
      send_read(3'd1, 3'd2);
      send_read(3'd1, 3'd0);

      // Converter 3 is pending when it leaves the mask, then time wraps backward.
      configure(4'b0001, 16'hFFFF);
      send_poll(32'd5, 1'b1, 16'h1234);
      send_poll(32'd5, 1'b0, 16'h0000);
      send_poll(32'd4, 1'b0, 16'h0000);
      send_poll(32'd65539, 1'b0, 16'h0000);
      send_poll(32'd65540, 1'b0, 16'h0000);
      send_poll(32'd65541, 1'b1, 16'hFFFF);
      send_read(3'd0, 3'd2);
      send_read(3'd7, 3'd3);

      now_ms = 32'd65541;
      for (int ph = 0; ph < PHASES; ph++) begin
         mask = (ph % 4 == 0) ? 4'hF : MASK_W'($urandom_range(0, 15));
         case (ph)
            1: timeout = '0;
            2: timeout = '1;
            default: timeout = (ph % 2) ? TIMEOUT_W'($urandom_range(0, 15))
                                        : TIMEOUT_W'($urandom);
         endcase
         configure(mask, timeout);
         sender_steady = (ph % 3 == 2);
         if (ph == 1) hold_request <= 1'b1;
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if ($urandom_range(0, 99) < 70) begin
               if ($urandom_range(0, 99) < 3) begin
                  now_ms = $urandom;
               end else begin
                  now_ms += $urandom_range(0, 8);
               end
               send_poll(now_ms, $urandom_range(0, 99) < 45, SAMPLE_W'($urandom));
            end else begin
               rd = ($urandom_range(0, 9) == 0) ? DEV_W'($urandom_range(4, 7))
                                                : DEV_W'($urandom_range(0, 3));
               rc = ($urandom_range(0, 9) == 0) ? CH_W'($urandom_range(4, 7))
                                                : CH_W'($urandom_range(0, 3));
               send_read(rd, rc);
            end
         end
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && results_due == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== adc_round_robin_scan_sequencer.f =====
design/adcscan_pkg.sv
design/adcscan_ctrl.sv
design/adcscan_store.sv
design/adc_round_robin_scan_sequencer.sv
tb/sv/scan_result_checker.sv
tb/sv/tb_adc_round_robin_scan_sequencer.sv
